### hdl/edd_pkg.sv
package edd_pkg;

    // fixed field widths
    localparam int PIX_W        = 8;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int THR_W        = 8;

    // error words carry this many integer bits above the fraction
    localparam int ERR_INT_BITS = 12;

    // grey levels
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    // Floyd-Steinberg weights, in sixteenths
    localparam int W_RIGHT       = 7;
    localparam int W_BELOW_LEFT  = 3;
    localparam int W_BELOW       = 5;
    localparam int W_BELOW_RIGHT = 1;
    localparam int W_SHIFT       = 4;

    // reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET = 13'd1920;
    localparam logic [THR_W-1:0]      THR_RESET   = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 1'b0,
        CFG_THRESHOLD   = 1'b1
    } t_cfg_idx;

endpackage

### hdl/edd_in_if.sv
interface edd_in_if;
    logic                       valid;
    logic                       ready;
    logic [edd_pkg::PIX_W-1:0]  pixel_in;
    logic                       frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

### hdl/edd_out_if.sv
interface edd_out_if;
    logic                       valid;
    logic                       ready;
    logic [edd_pkg::PIX_W-1:0]  pixel_out;
    logic                       row_end;

    modport source (output valid, output pixel_out, output row_end, input ready);
    modport sink   (input valid, input pixel_out, input row_end, output ready);
endinterface

### hdl/error_diffusion_dither_core.sv
// Floyd-Steinberg dither for 8-bit grey pixels in raster order, one pixel per
// clock sustained unless the output stalls. Each pixel gets the 7/16 carry of
// its left neighbour plus the error stored for its column by the row above, is
// compared against the threshold and leaves as 0 or 255; row_end flags the last
// pixel of a row. The errors for the next row live in one line buffer of
// MAX_WIDTH words (FRAC_BITS+12 bits, signed fixed point) with a registered
// read; the left-carry loop closes in the quantize stage, which sets the rate
// at one pixel per clock. Assert frame_start with the first pixel of each
// image: the first row then reads zero error and no buffer clear is needed.
// image_width and threshold must only be written while no pixel is in flight.
module error_diffusion_dither_core #(
    parameter int MAX_WIDTH = 4096,
    parameter int FRAC_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [edd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [edd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    edd_in_if.sink                            i_in_ch,
    edd_out_if.source                         o_out_ch
);

    localparam int ERR_W = FRAC_BITS + edd_pkg::ERR_INT_BITS;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int CMPW  = (CW > edd_pkg::CFG_DATA_W) ? CW : edd_pkg::CFG_DATA_W;

    // configuration
    logic [edd_pkg::CFG_DATA_W-1:0] r_width;
    logic [edd_pkg::THR_W-1:0]      r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= edd_pkg::WIDTH_RESET;
            r_thr   <= edd_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (edd_pkg::t_cfg_idx'(i_cfg_idx))
                edd_pkg::CFG_IMAGE_WIDTH: r_width <= i_cfg_wdata;
                edd_pkg::CFG_THRESHOLD:   r_thr   <= i_cfg_wdata[edd_pkg::THR_W-1:0];
            endcase
        end
    end

    // handshake: the output register frees the pipeline whenever it drains
    logic in_acc;
    logic in_rdy;
    logic out_free;
    logic s2_fire;
    logic r_s2_v;
    logic r_out_v;

    assign out_free       = !r_out_v || o_out_ch.ready;
    assign s2_fire        = r_s2_v && out_free;
    assign in_rdy         = !r_s2_v || s2_fire;
    assign i_in_ch.ready  = in_rdy;
    assign in_acc         = i_in_ch.valid && in_rdy;

    // column sequencing at acceptance
    logic [AW-1:0]   r_col;
    logic            r_first;
    logic [CMPW-1:0] w_x;
    logic [CMPW-1:0] max_x;
    logic [CMPW-1:0] w_eff;
    logic [CMPW-1:0] col_x;
    logic [CMPW-1:0] c_x;
    logic [CMPW-1:0] c_inc;
    logic            last_px;
    logic            first_px;
    logic [AW-1:0]   c_px;
    logic [AW-1:0]   n_col;
    logic            n_first;

    always_comb begin
        w_x   = CMPW'(r_width);
        max_x = CMPW'(MAX_WIDTH);
        if (w_x == '0) begin
            w_eff = CMPW'(1);
        end else if (w_x > max_x) begin
            w_eff = max_x;
        end else begin
            w_eff = w_x;
        end
        // frame start restarts the row and the first-row state
        col_x    = i_in_ch.frame_start ? '0 : CMPW'(r_col);
        first_px = i_in_ch.frame_start ? 1'b1 : r_first;
        // a width change mid row can leave the column past the end: clamp
        c_x      = (col_x >= w_eff) ? (w_eff - CMPW'(1)) : col_x;
        c_inc    = c_x + CMPW'(1);
        last_px  = (c_inc >= w_eff);
        c_px     = c_x[AW-1:0];
        n_col    = last_px ? '0 : c_inc[AW-1:0];
        n_first  = last_px ? 1'b0 : first_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
        end else if (in_acc) begin
            r_col   <= n_col;
            r_first <= n_first;
        end
    end

    // quantize stage registers
    logic [edd_pkg::PIX_W-1:0] r_s2_pix;
    logic                      r_s2_fs;
    logic                      r_s2_first;
    logic                      r_s2_last;
    logic [AW-1:0]             r_s2_c;
    logic                      r_fwd_hit;
    logic signed [ERR_W-1:0]   r_fwd_data;

    // diffusion state
    logic signed [ERR_W-1:0]   r_right;
    logic signed [ERR_W-1:0]   r_part_l;
    logic signed [ERR_W-1:0]   r_part_r;

    // deferred write of the entry below a row's last pixel
    logic                      r_pend_v;
    logic [AW-1:0]             r_pend_addr;
    logic signed [ERR_W-1:0]   r_pend_data;

    logic [ERR_W-1:0]          ram_rdata;
    logic signed [ERR_W-1:0]   below;
    logic signed [ERR_W-1:0]   right_in;
    logic signed [ERR_W-1:0]   part_l_in;
    logic signed [ERR_W-1:0]   part_r_in;
    logic                      q_hi;
    logic signed [ERR_W-1:0]   q_wr_left;
    logic signed [ERR_W-1:0]   q_wr_below;
    logic signed [ERR_W-1:0]   q_next_right;
    logic signed [ERR_W-1:0]   q_next_part;

    assign below     = r_s2_first ? '0 : (r_fwd_hit ? r_fwd_data : $signed(ram_rdata));
    assign right_in  = r_s2_fs ? '0 : r_right;
    assign part_l_in = r_s2_fs ? '0 : r_part_l;
    assign part_r_in = r_s2_fs ? '0 : r_part_r;

    edd_quant #(
        .FRAC_BITS (FRAC_BITS)
    ) u_quant (
        .i_pix        (r_s2_pix),
        .i_thr        (r_thr),
        .i_right      (right_in),
        .i_below      (below),
        .i_part_left  (part_l_in),
        .i_part_right (part_r_in),
        .o_hi         (q_hi),
        .o_wr_left    (q_wr_left),
        .o_wr_below   (q_wr_below),
        .o_next_right (q_next_right),
        .o_next_part  (q_next_part)
    );

    // line buffer write port: the lower-left share goes straight in; the
    // share below a row's last pixel waits one slot, which is always free
    // because the next pixel sits in column zero and has no lower-left write
    logic            has_left;
    logic [AW-1:0]   left_addr;
    logic            dir_we;
    logic            cap_we;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [ERR_W-1:0] ram_wdata;

    assign has_left  = (r_s2_c != '0);
    assign left_addr = r_s2_c - AW'(1);
    assign dir_we    = s2_fire && has_left;
    assign cap_we    = s2_fire && r_s2_last;
    assign ram_we    = dir_we || r_pend_v;
    assign ram_waddr = dir_we ? left_addr : r_pend_addr;
    assign ram_wdata = dir_we ? q_wr_left : r_pend_data;

    edd_ram #(
        .WIDTH (ERR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (c_px),
        .o_rdata (ram_rdata)
    );

    // forwarding: the read returns the old word, so catch any write to the
    // same entry that lands in the read cycle or still waits in the pending slot
    logic                    n_fwd_hit;
    logic signed [ERR_W-1:0] n_fwd_data;

    always_comb begin
        n_fwd_hit  = 1'b1;
        n_fwd_data = q_wr_left;
        if (dir_we && (left_addr == c_px)) begin
            n_fwd_data = q_wr_left;
        end else if (cap_we && (r_s2_c == c_px)) begin
            n_fwd_data = q_wr_below;
        end else if (r_pend_v && (r_pend_addr == c_px)) begin
            n_fwd_data = r_pend_data;
        end else begin
            n_fwd_hit  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (in_acc) begin
            r_s2_v <= 1'b1;
        end else if (s2_fire) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2_pix   <= i_in_ch.pixel_in;
            r_s2_fs    <= i_in_ch.frame_start;
            r_s2_first <= first_px;
            r_s2_last  <= last_px;
            r_s2_c     <= c_px;
            r_fwd_hit  <= n_fwd_hit;
            r_fwd_data <= n_fwd_data;
        end
    end

    // advance the carries; clear them at each row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right  <= '0;
            r_part_l <= '0;
            r_part_r <= '0;
        end else if (s2_fire) begin
            if (r_s2_last) begin
                r_right  <= '0;
                r_part_l <= '0;
                r_part_r <= '0;
            end else begin
                r_right  <= q_next_right;
                r_part_l <= q_wr_below;
                r_part_r <= q_next_part;
            end
        end
    end

    // pending slot: capture at row end, drain on any cycle without a direct write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (cap_we) begin
            r_pend_v <= 1'b1;
        end else if (!dir_we) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap_we) begin
            r_pend_addr <= r_s2_c;
            r_pend_data <= q_wr_below;
        end
    end

    // output register
    logic [edd_pkg::PIX_W-1:0] r_out_pix;
    logic                      r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s2_fire) begin
            r_out_v <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_out_pix <= q_hi ? edd_pkg::PIX_MAX : edd_pkg::PIX_MIN;
            r_out_end <= r_s2_last;
        end
    end

    assign o_out_ch.valid     = r_out_v;
    assign o_out_ch.pixel_out = r_out_pix;
    assign o_out_ch.row_end   = r_out_end;

    // the pending slot must be empty whenever a lower-left write takes the port
    a_pend_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dir_we |-> !r_pend_v)
        else $error("line buffer write port clash");

    // a quantized pixel always lands in the output register
    a_fire_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_fire |=> r_out_v)
        else $error("quantized pixel lost");

    // an empty output register never blocks the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> in_rdy)
        else $error("input stalled with empty output register");

    // a row end always restarts at column zero
    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && last_px) |=> (r_col == '0))
        else $error("column not cleared at row end");

endmodule

### hdl/edd_ram.sv
module edd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/edd_quant.sv
module edd_quant #(
    parameter int FRAC_BITS = 8
) (
    input  logic [edd_pkg::PIX_W-1:0]                        i_pix,
    input  logic [edd_pkg::THR_W-1:0]                        i_thr,
    input  logic signed [FRAC_BITS+edd_pkg::ERR_INT_BITS-1:0] i_right,
    input  logic signed [FRAC_BITS+edd_pkg::ERR_INT_BITS-1:0] i_below,
    input  logic signed [FRAC_BITS+edd_pkg::ERR_INT_BITS-1:0] i_part_left,
    input  logic signed [FRAC_BITS+edd_pkg::ERR_INT_BITS-1:0] i_part_right,
    output logic                                             o_hi,
    output logic signed [FRAC_BITS+edd_pkg::ERR_INT_BITS-1:0] o_wr_left,
    output logic signed [FRAC_BITS+edd_pkg::ERR_INT_BITS-1:0] o_wr_below,
    output logic signed [FRAC_BITS+edd_pkg::ERR_INT_BITS-1:0] o_next_right,
    output logic signed [FRAC_BITS+edd_pkg::ERR_INT_BITS-1:0] o_next_part
);

    localparam int ERR_W = FRAC_BITS + edd_pkg::ERR_INT_BITS;
    localparam int ACC_W = ERR_W + 2;
    localparam int PRD_W = ERR_W + edd_pkg::W_SHIFT;
    localparam int PAD_W = ACC_W - edd_pkg::PIX_W - FRAC_BITS;

    localparam logic signed [ACC_W-1:0] ERR_HI_X = ACC_W'((64'sd1 <<< (ERR_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ERR_LO_X = -ERR_HI_X - ACC_W'(1);

    function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ACC_W-1:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > ERR_HI_X) begin
            r = ERR_HI_X[ERR_W-1:0];
        end else if (v < ERR_LO_X) begin
            r = ERR_LO_X[ERR_W-1:0];
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] ext(input logic signed [ERR_W-1:0] v);
        return $signed({{(ACC_W-ERR_W){v[ERR_W-1]}}, v});
    endfunction

    // floor(k * e / 16): arithmetic shift of the product
    function automatic logic signed [ERR_W-1:0] share(input logic signed [ERR_W-1:0] e,
                                                       input int k);
        logic signed [PRD_W-1:0] ex;
        logic signed [PRD_W-1:0] prod;
        ex   = $signed({{(PRD_W-ERR_W){e[ERR_W-1]}}, e});
        prod = ex * $signed(PRD_W'(k));
        return prod[PRD_W-1:edd_pkg::W_SHIFT];
    endfunction

    logic signed [ACC_W-1:0] pix_x;
    logic signed [ACC_W-1:0] thr_x;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] out_x;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] sh_r;
    logic signed [ERR_W-1:0] sh_bl;
    logic signed [ERR_W-1:0] sh_b;
    logic signed [ERR_W-1:0] sh_br;

    assign pix_x = $signed({{PAD_W{1'b0}}, i_pix, {FRAC_BITS{1'b0}}});
    assign thr_x = $signed({{PAD_W{1'b0}}, i_thr, {FRAC_BITS{1'b0}}});
    assign acc   = pix_x + ext(i_right) + ext(i_below);
    assign o_hi  = (acc >= thr_x);
    assign out_x = o_hi ? $signed({{PAD_W{1'b0}}, edd_pkg::PIX_MAX, {FRAC_BITS{1'b0}}})
                        : $signed({{PAD_W{1'b0}}, edd_pkg::PIX_MIN, {FRAC_BITS{1'b0}}});
    assign err   = sat_err(acc - out_x);

    assign sh_r  = share(err, edd_pkg::W_RIGHT);
    assign sh_bl = share(err, edd_pkg::W_BELOW_LEFT);
    assign sh_b  = share(err, edd_pkg::W_BELOW);
    assign sh_br = share(err, edd_pkg::W_BELOW_RIGHT);

    assign o_wr_left    = sat_err(ext(i_part_left) + ext(sh_bl));
    assign o_wr_below   = sat_err(ext(i_part_right) + ext(sh_b));
    assign o_next_right = sat_err(ext(sh_r));
    assign o_next_part  = sh_br;

endmodule
